/* design/pagerank_edge_accumulate_macros.svh */
// assertion macros for the checker file
`ifndef PAGERANK_EDGE_ACCUMULATE_MACROS_SVH
`define PAGERANK_EDGE_ACCUMULATE_MACROS_SVH

// same-cycle implication
`define PR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pr_acc_pkg.sv */
// ----------------------------------------------------------------------------
// pr_acc_pkg
// shared constants, codes and types of the pagerank edge accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package pr_acc_pkg;

  localparam int NODE_CAPACITY_DEF = 65536;

  localparam int NODE_W   = 16;
  localparam int RANK_W   = 32;
  localparam int DEGREE_W = 24;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [RANK_W-1:0]   ONE_Q16    = 32'd65536;
  localparam logic [RANK_W-1:0]   RANK_MAX   = 32'hFFFF_FFFF;
  localparam logic [DEGREE_W-1:0] DEGREE_MAX = 24'hFF_FFFF;
  localparam logic [CFG_W-1:0]    NODE_COUNT_RST = 17'd65536;
  localparam logic [CFG_W-1:0]    DAMPING_RST    = 17'd55706;
  localparam logic [CFG_W-1:0]    DAMPING_ONE    = 17'd65536;

  localparam logic [1:0] OP_DEGREE    = 2'd0;
  localparam logic [1:0] OP_PROPAGATE = 2'd1;
  localparam logic [1:0] OP_UPDATE    = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

/* design/pr_acc_ram.sv */
// ----------------------------------------------------------------------------
// pr_acc_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pr_acc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = pr_acc_pkg::NODE_CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/pr_acc_div.sv */
// ----------------------------------------------------------------------------
// pr_acc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pr_acc_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [pr_acc_pkg::RANK_W-1:0]       dividend,
  input  wire logic [pr_acc_pkg::DEGREE_W-1:0]     divisor,
  output logic                                     done,
  output logic      [pr_acc_pkg::RANK_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(pr_acc_pkg::RANK_W);

  logic                                busy;
  logic [CNT_W-1:0]                    cnt;
  logic [pr_acc_pkg::DEGREE_W-1:0]     dvs;
  logic [pr_acc_pkg::DEGREE_W-1:0]     rem;
  logic [pr_acc_pkg::DEGREE_W:0]       trial;
  logic                                qbit;

  assign trial = {rem, quotient[pr_acc_pkg::RANK_W-1]};
  assign qbit  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(pr_acc_pkg::RANK_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= qbit ? pr_acc_pkg::DEGREE_W'(trial - {1'b0, dvs})
                       : trial[pr_acc_pkg::DEGREE_W-1:0];
      quotient <= {quotient[pr_acc_pkg::RANK_W-2:0], qbit};
    end
  end

endmodule

`default_nettype wire

/* design/pagerank_edge_accumulate.sv */
// ----------------------------------------------------------------------------
// pagerank_edge_accumulate
// per-node rank, out-degree and partial sum kept in on-chip memories;
// degree count, edge propagation and rank update done by read-modify-write
// ----------------------------------------------------------------------------
//  channel  | signals                              | direction
//  in       | in_valid in_ready op from_node to_node| to block
//  out      | out_valid out_ready node rank_value   | from block
//  cfg      | cfg_we cfg_index cfg_data             | to block
//
//  op 0: accept, memory read, write back
//  ops 1 and 2: accept, memory read, the 32-step shared divider, write back;
//  op 1 from a zero-degree source skips the divider, an ignored transaction is dropped
//  one item at a time; the memories are read and written back before
//  the next item is taken, so no two accesses to an entry overlap
//  after reset a clearing pass over every entry holds in_ready low
//  a rank update waits in its last step while the output register is full
// ----------------------------------------------------------------------------
`default_nettype none

module pagerank_edge_accumulate #(
  parameter int NODE_CAPACITY = pr_acc_pkg::NODE_CAPACITY_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           op,
  input  wire logic [pr_acc_pkg::NODE_W-1:0]        from_node,
  input  wire logic [pr_acc_pkg::NODE_W-1:0]        to_node,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic      [pr_acc_pkg::NODE_W-1:0]        node,
  output logic      [pr_acc_pkg::RANK_W-1:0]        rank_value,
  input  wire logic                                 cfg_we,
  input  wire logic [pr_acc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pr_acc_pkg::CFG_W-1:0]         cfg_data
);

  localparam int AW  = $clog2(NODE_CAPACITY);
  localparam int AD_W = pr_acc_pkg::RANK_W + pr_acc_pkg::DEGREE_W;
  localparam int PROD_W = pr_acc_pkg::CFG_W + pr_acc_pkg::RANK_W;

  pr_acc_pkg::state_t state, state_next;

  logic [pr_acc_pkg::CFG_W-1:0]  node_count;
  logic [pr_acc_pkg::CFG_W-1:0]  damping_q16;
  logic [1:0]                    op_q;
  logic [pr_acc_pkg::NODE_W-1:0] src_q;
  logic [pr_acc_pkg::NODE_W-1:0] dst_q;
  logic [AW-1:0]                 clr_addr;
  logic [PROD_W-1:0]             prod;

  logic                          item_ok;
  logic                          slot_free;
  logic [pr_acc_pkg::CFG_W-1:0]  d_eff;
  logic [pr_acc_pkg::CFG_W-1:0]  n_eff;

  logic                          a_we, a_re, b_we, b_re;
  logic [AW-1:0]                 a_waddr, a_raddr, b_waddr, b_raddr;
  logic [AD_W-1:0]               a_wdata, a_rd;
  logic [pr_acc_pkg::RANK_W-1:0] b_wdata, b_rd;

  logic [pr_acc_pkg::RANK_W-1:0]   rank_rd;
  logic [pr_acc_pkg::DEGREE_W-1:0] deg_rd;
  logic [pr_acc_pkg::DEGREE_W-1:0] deg_inc;
  logic [pr_acc_pkg::RANK_W:0]     sum_add;
  logic [pr_acc_pkg::RANK_W-1:0]   sum_sat;
  logic [PROD_W-16:0]              total;
  logic [pr_acc_pkg::RANK_W-1:0]   total_sat;

  logic                            div_start, div_done;
  logic [pr_acc_pkg::RANK_W-1:0]   div_dividend, div_quotient;
  logic [pr_acc_pkg::DEGREE_W-1:0] div_divisor;
  logic                            out_load;

  assign rank_rd = a_rd[AD_W-1:pr_acc_pkg::DEGREE_W];
  assign deg_rd  = a_rd[pr_acc_pkg::DEGREE_W-1:0];
  assign d_eff   = (damping_q16 > pr_acc_pkg::DAMPING_ONE) ? pr_acc_pkg::DAMPING_ONE
                                                            : damping_q16;
  assign n_eff   = (node_count == '0) ? pr_acc_pkg::CFG_W'(1) : node_count;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    case (op)
      pr_acc_pkg::OP_DEGREE:
        item_ok = 32'(from_node) < 32'(NODE_CAPACITY);
      pr_acc_pkg::OP_PROPAGATE:
        item_ok = (32'(from_node) < 32'(NODE_CAPACITY)) &&
                  (32'(to_node) < 32'(NODE_CAPACITY));
      pr_acc_pkg::OP_UPDATE:
        item_ok = 32'(to_node) < 32'(NODE_CAPACITY);
      default:
        item_ok = 1'b0;
    endcase
  end

  assign deg_inc = (deg_rd == pr_acc_pkg::DEGREE_MAX) ? deg_rd : deg_rd + 1'b1;
  assign sum_add = {1'b0, b_rd} + {1'b0, div_quotient};
  assign sum_sat = sum_add[pr_acc_pkg::RANK_W] ? pr_acc_pkg::RANK_MAX
                                               : sum_add[pr_acc_pkg::RANK_W-1:0];
  assign total   = (PROD_W-15)'(prod[PROD_W-1:16]) + (PROD_W-15)'(div_quotient);
  assign total_sat = (total > (PROD_W-15)'(pr_acc_pkg::RANK_MAX)) ? pr_acc_pkg::RANK_MAX
                                               : total[pr_acc_pkg::RANK_W-1:0];

  assign div_dividend = (op_q == pr_acc_pkg::OP_UPDATE)
                      ? pr_acc_pkg::RANK_W'(pr_acc_pkg::ONE_Q16 - pr_acc_pkg::RANK_W'(d_eff))
                      : rank_rd;
  assign div_divisor  = (op_q == pr_acc_pkg::OP_UPDATE)
                      ? pr_acc_pkg::DEGREE_W'(n_eff) : deg_rd;

  assign a_raddr = (op_q == pr_acc_pkg::OP_UPDATE) ? AW'(dst_q) : AW'(src_q);
  assign b_raddr = AW'(dst_q);

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    a_re       = 1'b0;
    b_re       = 1'b0;
    a_we       = 1'b0;
    b_we       = 1'b0;
    a_waddr    = a_raddr;
    b_waddr    = b_raddr;
    a_wdata    = {rank_rd, deg_inc};
    b_wdata    = sum_sat;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      pr_acc_pkg::ST_CLEAR: begin
        a_we    = 1'b1;
        b_we    = 1'b1;
        a_waddr = clr_addr;
        b_waddr = clr_addr;
        a_wdata = {pr_acc_pkg::ONE_Q16, pr_acc_pkg::DEGREE_W'(0)};
        b_wdata = '0;
        if (clr_addr == AW'(NODE_CAPACITY - 1)) begin
          state_next = pr_acc_pkg::ST_IDLE;
        end
      end
      pr_acc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && item_ok) begin
          state_next = pr_acc_pkg::ST_READ;
        end
      end
      pr_acc_pkg::ST_READ: begin
        a_re       = 1'b1;
        b_re       = 1'b1;
        state_next = pr_acc_pkg::ST_EXEC;
      end
      pr_acc_pkg::ST_EXEC: begin
        if (op_q == pr_acc_pkg::OP_DEGREE) begin
          a_we       = 1'b1;
          state_next = pr_acc_pkg::ST_IDLE;
        end else if (op_q == pr_acc_pkg::OP_PROPAGATE && deg_rd == '0) begin
          state_next = pr_acc_pkg::ST_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = pr_acc_pkg::ST_DIV;
        end
      end
      pr_acc_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = pr_acc_pkg::ST_FIN;
        end
      end
      pr_acc_pkg::ST_FIN: begin
        if (op_q == pr_acc_pkg::OP_PROPAGATE) begin
          b_we       = 1'b1;
          state_next = pr_acc_pkg::ST_IDLE;
        end else if (slot_free) begin
          a_we       = 1'b1;
          b_we       = 1'b1;
          a_wdata    = {total_sat, deg_rd};
          b_wdata    = '0;
          out_load   = 1'b1;
          state_next = pr_acc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pr_acc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pr_acc_pkg::ST_CLEAR;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
      node_count  <= pr_acc_pkg::NODE_COUNT_RST;
      damping_q16 <= pr_acc_pkg::DAMPING_RST;
    end else begin
      state <= state_next;
      if (state == pr_acc_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we && cfg_index == pr_acc_pkg::REG_NODE_COUNT) begin
        node_count <= cfg_data;
      end
      if (cfg_we && cfg_index == pr_acc_pkg::REG_DAMPING) begin
        damping_q16 <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q  <= op;
      src_q <= from_node;
      dst_q <= to_node;
    end
    if (state == pr_acc_pkg::ST_EXEC) begin
      prod <= PROD_W'(d_eff) * PROD_W'(b_rd);
    end
    if (out_load) begin
      node       <= dst_q;
      rank_value <= total_sat;
    end
  end

  pr_acc_ram #(
    .WIDTH (AD_W),
    .DEPTH (NODE_CAPACITY)
  ) u_rank_deg (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  pr_acc_ram #(
    .WIDTH (pr_acc_pkg::RANK_W),
    .DEPTH (NODE_CAPACITY)
  ) u_sum (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  pr_acc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

`default_nettype wire

/* design/pr_acc_checker.sv */
// ----------------------------------------------------------------------------
// pr_acc_checker
// port-level checks of the pagerank edge accumulator
// ----------------------------------------------------------------------------
`default_nettype none

`include "pagerank_edge_accumulate_macros.svh"

module pr_acc_checker #(
  parameter int NODE_CAPACITY = pr_acc_pkg::NODE_CAPACITY_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [1:0]                    op,
  input wire logic [pr_acc_pkg::NODE_W-1:0] from_node,
  input wire logic [pr_acc_pkg::NODE_W-1:0] to_node,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [15:0]                   node,
  input wire logic [31:0]                   rank_value
);

  logic taken;

  // transactions that start work; ignored ones leave the input open
  always_comb begin
    case (op)
      pr_acc_pkg::OP_DEGREE:
        taken = 32'(from_node) < 32'(NODE_CAPACITY);
      pr_acc_pkg::OP_PROPAGATE:
        taken = (32'(from_node) < 32'(NODE_CAPACITY)) &&
                (32'(to_node) < 32'(NODE_CAPACITY));
      pr_acc_pkg::OP_UPDATE:
        taken = 32'(to_node) < 32'(NODE_CAPACITY);
      default:
        taken = 1'b0;
    endcase
  end

  `PR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(node) && $stable(rank_value), "output transaction changed while stalled")
  `PR_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready && taken, !in_ready, "new transaction taken before the current one finished")
  `PR_ASSERT_NOW(a_clear_pass, clk, 1'b0, $past(rst), !in_ready, "input taken during the clearing pass")

endmodule

bind pagerank_edge_accumulate pr_acc_checker #(
  .NODE_CAPACITY (NODE_CAPACITY)
) u_pr_acc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .op         (op),
  .from_node  (from_node),
  .to_node    (to_node),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .node       (node),
  .rank_value (rank_value)
);

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// pagerank edge accumulator testbench
// drives degree, propagate and update transactions with random stalls on both
// channels, predicts each new rank from local copies of the node stores and
// checks every output transaction field by field against the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

class rank_scoreboard;
  logic [pr_acc_pkg::RANK_W-1:0]   rank_mem   [int];
  logic [pr_acc_pkg::DEGREE_W-1:0] degree_mem [int];
  logic [pr_acc_pkg::RANK_W-1:0]   sum_mem    [int];
  logic [pr_acc_pkg::CFG_W-1:0]    node_count;
  logic [pr_acc_pkg::CFG_W-1:0]    damping;
  logic [pr_acc_pkg::NODE_W-1:0]   exp_node [$];
  logic [pr_acc_pkg::RANK_W-1:0]   exp_rank [$];
  int errors;
  int updates_seen;

  function new();
    node_count = pr_acc_pkg::NODE_COUNT_RST;
    damping = pr_acc_pkg::DAMPING_RST;
    errors = 0;
    updates_seen = 0;
  endfunction

  function void write_reg(logic [pr_acc_pkg::CFG_IDX_W-1:0] idx,
                          logic [pr_acc_pkg::CFG_W-1:0] data);
    if (idx == pr_acc_pkg::REG_NODE_COUNT) node_count = data;
    else if (idx == pr_acc_pkg::REG_DAMPING) damping = data;
  endfunction

  function logic [pr_acc_pkg::RANK_W-1:0] rank_of(int k);
    return rank_mem.exists(k) ? rank_mem[k] : pr_acc_pkg::ONE_Q16;
  endfunction

  function logic [pr_acc_pkg::DEGREE_W-1:0] degree_of(int k);
    return degree_mem.exists(k) ? degree_mem[k] : '0;
  endfunction

  function logic [pr_acc_pkg::RANK_W-1:0] sum_of(int k);
    return sum_mem.exists(k) ? sum_mem[k] : '0;
  endfunction

  function void note_input(logic [1:0] op, logic [pr_acc_pkg::NODE_W-1:0] src,
                           logic [pr_acc_pkg::NODE_W-1:0] dst);
    logic [63:0] acc;
    logic [pr_acc_pkg::RANK_W-1:0] share;
    logic [pr_acc_pkg::CFG_W-1:0] d, n;
    logic [pr_acc_pkg::RANK_W-1:0] teleport;
    if (op == pr_acc_pkg::OP_DEGREE) begin
      if (degree_of(src) != pr_acc_pkg::DEGREE_MAX) degree_mem[src] = degree_of(src) + 1'b1;
    end else if (op == pr_acc_pkg::OP_PROPAGATE) begin
      if (degree_of(src) != 0) begin
        share = rank_of(src) / degree_of(src);
        acc = 64'(sum_of(dst)) + 64'(share);
        sum_mem[dst] = (acc > 64'(pr_acc_pkg::RANK_MAX)) ? pr_acc_pkg::RANK_MAX : acc[31:0];
      end
    end else if (op == pr_acc_pkg::OP_UPDATE) begin
      d = (damping > pr_acc_pkg::DAMPING_ONE) ? pr_acc_pkg::DAMPING_ONE : damping;
      n = (node_count == 0) ? 17'd1 : node_count;
      teleport = (32'd65536 - 32'(d)) / 32'(n);
      acc = ((64'(d) * 64'(sum_of(dst))) >> 16) + 64'(teleport);
      if (acc > 64'(pr_acc_pkg::RANK_MAX)) acc = 64'(pr_acc_pkg::RANK_MAX);
      rank_mem[dst] = acc[31:0];
      sum_mem[dst] = '0;
      exp_node = {exp_node, dst};
      exp_rank = {exp_rank, acc[31:0]};
    end
  endfunction

  function void check_result(logic [pr_acc_pkg::NODE_W-1:0] nd,
                             logic [pr_acc_pkg::RANK_W-1:0] rv);
    logic [pr_acc_pkg::NODE_W-1:0] en;
    logic [pr_acc_pkg::RANK_W-1:0] er;
    updates_seen++;
    if (exp_node.size() == 0) begin
      $error("unexpected output transaction node=%0d rank_value=%0h", nd, rv);
      errors++;
      return;
    end
    en = exp_node.pop_front();
    er = exp_rank.pop_front();
    if (nd !== en) begin
      $error("node: expected %0d actual %0d", en, nd);
      errors++;
    end
    if (rv !== er) begin
      $error("rank_value: expected %0h actual %0h", er, rv);
      errors++;
    end
  endfunction

  function int pending();
    return exp_node.size();
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = pr_acc_pkg::OP_DEGREE;
  logic [pr_acc_pkg::NODE_W-1:0] from_node = '0;
  logic [pr_acc_pkg::NODE_W-1:0] to_node = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [pr_acc_pkg::NODE_W-1:0] node;
  logic [pr_acc_pkg::RANK_W-1:0] rank_value;
  logic cfg_we = 1'b0;
  logic [pr_acc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pr_acc_pkg::CFG_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int cycle_count = 0;
  int items_sent = 0;

  rank_scoreboard sb = new();

  pagerank_edge_accumulate dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // output side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(node, rank_value);
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays high after a transaction unless the sender idles next
  task automatic send_item(logic [1:0] o, logic [pr_acc_pkg::NODE_W-1:0] s,
                           logic [pr_acc_pkg::NODE_W-1:0] t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    op <= o;
    from_node <= s;
    to_node <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(o, s, t);
    items_sent++;
  endtask

  task automatic write_reg(logic [pr_acc_pkg::CFG_IDX_W-1:0] idx,
                           logic [pr_acc_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [pr_acc_pkg::NODE_W-1:0] pick_node();
    case ($urandom_range(3))
      0: return pr_acc_pkg::NODE_W'($urandom_range(7));
      1: return pr_acc_pkg::NODE_W'($urandom_range(65535));
      2: return pr_acc_pkg::NODE_W'(65535 - $urandom_range(3));
      default: return pr_acc_pkg::NODE_W'($urandom_range(31));
    endcase
  endfunction

  // one small graph: count degrees, propagate edges, then update every destination node
  task automatic run_graph(int edges);
    logic [pr_acc_pkg::NODE_W-1:0] src [$];
    logic [pr_acc_pkg::NODE_W-1:0] dst [$];
    logic [pr_acc_pkg::NODE_W-1:0] nodes [$];
    logic [pr_acc_pkg::NODE_W-1:0] a, b;
    for (int i = 0; i < edges; i++) begin
      a = pick_node();
      b = pick_node();
      src = {src, a};
      dst = {dst, b};
      nodes = {nodes, b};
      send_item(pr_acc_pkg::OP_DEGREE, a, pr_acc_pkg::NODE_W'($urandom));
    end
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(19) == 0) send_item(pr_acc_pkg::OP_UNUSED, pick_node(), pick_node());
      send_item(pr_acc_pkg::OP_PROPAGATE, src[i], dst[i]);
    end
    foreach (nodes[i]) send_item(pr_acc_pkg::OP_UPDATE, pr_acc_pkg::NODE_W'($urandom), nodes[i]);
  endtask

  initial begin
    logic [pr_acc_pkg::CFG_W-1:0] n_cfg [4] = '{17'd1, 17'd65536, 17'd0, 17'd100};
    logic [pr_acc_pkg::CFG_W-1:0] d_cfg [4] = '{17'd0, 17'd65536, 17'd131071, 17'd55706};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero degree, unknown op, ignored register index
    send_item(pr_acc_pkg::OP_PROPAGATE, 16'd5, 16'd6);
    send_item(pr_acc_pkg::OP_UPDATE, 16'd0, 16'd6);
    send_item(pr_acc_pkg::OP_UNUSED, 16'hFFFF, 16'hFFFF);
    send_item(pr_acc_pkg::OP_DEGREE, 16'hFFFF, 16'h0000);
    send_item(pr_acc_pkg::OP_DEGREE, 16'h0000, 16'hFFFF);
    send_item(pr_acc_pkg::OP_PROPAGATE, 16'hFFFF, 16'h0000);
    send_item(pr_acc_pkg::OP_PROPAGATE, 16'h0000, 16'hFFFF);
    send_item(pr_acc_pkg::OP_PROPAGATE, 16'h0000, 16'hFFFF);
    send_item(pr_acc_pkg::OP_UPDATE, 16'hFFFF, 16'hFFFF);
    send_item(pr_acc_pkg::OP_UPDATE, 16'hAAAA, 16'h0000);
    send_item(pr_acc_pkg::OP_UPDATE, 16'h5555, 16'h5555);
    wait_idle();
    write_reg(pr_acc_pkg::REG_UNUSED_HI, 17'h1FFFF);
    write_reg(pr_acc_pkg::REG_UNUSED_LO, 17'd7);

    // long receiver hold-off while updates keep coming
    hold_off <= 1'b1;
    fork
      begin
        repeat (2000) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_item(pr_acc_pkg::OP_UPDATE, '0, pr_acc_pkg::NODE_W'(i));
    join
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 6 : 0;
      for (int k = 0; k < 4; k++) begin
        wait_idle();
        write_reg(pr_acc_pkg::REG_NODE_COUNT, n_cfg[(k + phase) % 4]);
        write_reg(pr_acc_pkg::REG_DAMPING, d_cfg[k]);
        // often-picked low node numbers raise sums toward saturation under full damping
        for (int g = 0; g < 2; g++) run_graph($urandom_range(10, 40));
      end
    end

    wait_idle();
    $display("covered %0d transactions in, %0d rank updates out, across register settings",
             items_sent, sb.updates_seen);
    $display("with random and long stalls on both channels");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
